// ===== design/masked_box_blur_composite_defines.svh =====
// ----------------------------------------------------------------------------
// masked_box_blur_composite_defines.svh
// Assertion helper macros shared by the compositor modules.
// ----------------------------------------------------------------------------
`ifndef MASKED_BOX_BLUR_COMPOSITE_DEFINES_SVH
`define MASKED_BOX_BLUR_COMPOSITE_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define MBBC_ASSERT_ALW(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define MBBC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define MBBC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mbbc_pkg.sv =====
// ----------------------------------------------------------------------------
// mbbc_pkg
// Types and constants shared by the masked box blur compositor.
// ----------------------------------------------------------------------------
package mbbc_pkg;

   // Configuration register fields
   localparam int CFG_DIM_W    = 11;
   localparam int CFG_RADIUS_W = 5;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 11;

   localparam logic [CFG_DIM_W-1:0]    WIDTH_RST  = 11'd960;
   localparam logic [CFG_DIM_W-1:0]    HEIGHT_RST = 11'd540;
   localparam logic [CFG_RADIUS_W-1:0] RADIUS_RST = 5'd3;

   localparam int MIN_RADIUS  = 3;
   localparam logic [7:0] PIXEL_MAX   = 8'hFF;
   localparam logic [16:0] BLEND_ROUND = 17'd127;

   // Request codes
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // Queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT,
      CSR_BLUR_RADIUS,
      CSR_BACKDROP_MODE
   } csr_index_type;

   typedef struct packed {
      logic [CFG_DIM_W-1:0]    frame_width;
      logic [CFG_DIM_W-1:0]    frame_height;
      logic [CFG_RADIUS_W-1:0] blur_radius;
      logic                    backdrop_mode;
   } cfg_type;

   typedef struct packed {
      logic       is_read;
      logic [7:0] pixel_blue;
      logic [7:0] pixel_green;
      logic [7:0] pixel_red;
      logic [7:0] pixel_alpha;
      logic [7:0] mask_level;
      logic [7:0] backdrop_blue;
      logic [7:0] backdrop_green;
      logic [7:0] backdrop_red;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRE_A,
      ST_PRE_R,
      ST_PRE_U,
      ST_DIV_S,
      ST_DIV_W,
      ST_WR,
      ST_ADD_R,
      ST_ADD_U,
      ST_SUB_R,
      ST_SUB_U,
      ST_RD_F,
      ST_RD_M,
      ST_RD_S
   } back_state_type;

endpackage

// ===== design/masked_box_blur_composite.sv =====
// ----------------------------------------------------------------------------
// masked_box_blur_composite
// Frame compositor: box blurred or backdrop background under a person mask.
// ----------------------------------------------------------------------------
// Usage:
//  Request channel (req_*): req_type 0 writes the next frame pixel with its
//  mask level and backdrop pixel, req_type 1 reads the next result pixel.
//  Result channel (rsp_*): one item per read, none per write. read_status
//  is set when no finished frame pixel is available.
//  Register port (csr_*): always ready; write only while the block is idle.
//  A write is stored in the frame memories when the back end pops it from
//  the queue; a read passes through ST_RD_F, ST_RD_M and ST_RD_S to the
//  result register, or is answered from idle when no frame is ready. The
//  last write of a frame in blur mode starts four box passes; each line of
//  a pass first fills the window of 2r+1 pixels, then per pixel runs the
//  divider and two single-port reads; requests queue up meanwhile.
//  Throughput is set by the single read port of each frame memory.
//  Reset clears counters and the result slot; frame memories need none.
//  A stalled receiver holds the result; two more requests queue behind it.
// ----------------------------------------------------------------------------
module masked_box_blur_composite #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_RADIUS = 31
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [7:0]                          req_pixel_blue,
   input  logic [7:0]                          req_pixel_green,
   input  logic [7:0]                          req_pixel_red,
   input  logic [7:0]                          req_pixel_alpha,
   input  logic [7:0]                          req_mask_level,
   input  logic [7:0]                          req_backdrop_blue,
   input  logic [7:0]                          req_backdrop_green,
   input  logic [7:0]                          req_backdrop_red,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_out_blue,
   output logic [7:0]                          rsp_out_green,
   output logic [7:0]                          rsp_out_red,
   output logic [7:0]                          rsp_out_alpha,
   output logic                                rsp_last_pixel,
   output logic                                rsp_read_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mbbc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mbbc_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   qhead_type head;
   logic      cmd_pop;

   assign csr_ready = 1'b1;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:   cfg_in.frame_width   = csr_wdata[CFG_DIM_W-1:0];
            CSR_FRAME_HEIGHT:  cfg_in.frame_height  = csr_wdata[CFG_DIM_W-1:0];
            CSR_BLUR_RADIUS:   cfg_in.blur_radius   = csr_wdata[CFG_RADIUS_W-1:0];
            CSR_BACKDROP_MODE: cfg_in.backdrop_mode = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width   <= WIDTH_RST;
         cfg_ff.frame_height  <= HEIGHT_RST;
         cfg_ff.blur_radius   <= RADIUS_RST;
         cfg_ff.backdrop_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbbc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_pixel_blue     (req_pixel_blue),
      .req_pixel_green    (req_pixel_green),
      .req_pixel_red      (req_pixel_red),
      .req_pixel_alpha    (req_pixel_alpha),
      .req_mask_level     (req_mask_level),
      .req_backdrop_blue  (req_backdrop_blue),
      .req_backdrop_green (req_backdrop_green),
      .req_backdrop_red   (req_backdrop_red),
      .head               (head),
      .cmd_pop            (cmd_pop)
   );

   mbbc_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head            (head),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_alpha   (rsp_out_alpha),
      .rsp_last_pixel  (rsp_last_pixel),
      .rsp_read_status (rsp_read_status)
   );
endmodule

// ===== design/mbbc_ram.sv =====
// ----------------------------------------------------------------------------
// mbbc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mbbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/mbbc_front.sv =====
// ----------------------------------------------------------------------------
// mbbc_front
// Accepts request items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`include "masked_box_blur_composite_defines.svh"

module mbbc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [7:0]          req_pixel_blue,
   input  logic [7:0]          req_pixel_green,
   input  logic [7:0]          req_pixel_red,
   input  logic [7:0]          req_pixel_alpha,
   input  logic [7:0]          req_mask_level,
   input  logic [7:0]          req_backdrop_blue,
   input  logic [7:0]          req_backdrop_green,
   input  logic [7:0]          req_backdrop_red,
   output mbbc_pkg::qhead_type head,
   input  logic                cmd_pop
);
   import mbbc_pkg::*;

   cmd_type             q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   cmd_type             cmd;

   // Classify the incoming item
   always_comb begin
      cmd.is_read        = (req_type == REQ_READ);
      cmd.pixel_blue     = req_pixel_blue;
      cmd.pixel_green    = req_pixel_green;
      cmd.pixel_red      = req_pixel_red;
      cmd.pixel_alpha    = req_pixel_alpha;
      cmd.mask_level     = req_mask_level;
      cmd.backdrop_blue  = req_backdrop_blue;
      cmd.backdrop_green = req_backdrop_green;
      cmd.backdrop_red   = req_backdrop_red;
   end

   assign req_ready = (count_ff != QCNT_W'(QDEPTH));
   assign push      = req_valid && req_ready;

   // Advance pointers and fill count
   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = cmd_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = q_ff[rptr_ff];

   `MBBC_ASSERT_IMP(a_pop_nonempty, clock, reset, cmd_pop, count_ff != '0, "pop from empty queue")
endmodule

// ===== design/mbbc_div.sv =====
// ----------------------------------------------------------------------------
// mbbc_div
// Three-lane restoring divider: one quotient bit per cycle, 8-bit quotients.
// ----------------------------------------------------------------------------
`include "masked_box_blur_composite_defines.svh"

module mbbc_div #(
   parameter int SUM_W = 14,
   parameter int DMW   = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0][SUM_W-1:0] dividend,
   input  logic [DMW-1:0]        divisor,
   output logic [2:0][7:0]       quotient,
   output logic                  done
);
   import mbbc_pkg::*;

   localparam int CMP_W = SUM_W + 8;

   logic [2:0][SUM_W-1:0] rem_ff, rem_in;
   logic [2:0][7:0]       q_ff, q_in;
   logic [2:0]            step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CMP_W-1:0]      dsh;

   // One quotient bit per lane each cycle
   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dsh     = CMP_W'(divisor) << step_ff;
      if (start) begin
         rem_in  = dividend;
         q_in    = '0;
         step_in = 3'd7;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int c = 0; c < 3; c++) begin
            if (CMP_W'(rem_ff[c]) >= dsh) begin
               rem_in[c]        = rem_ff[c] - dsh[SUM_W-1:0];
               q_in[c][step_ff] = 1'b1;
            end
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign quotient = q_ff;
   assign done     = done_ff;

   `MBBC_ASSERT_IMP(a_no_restart, clock, reset, start, !busy_ff, "divider started while busy")
endmodule

// ===== design/mbbc_back.sv =====
// ----------------------------------------------------------------------------
// mbbc_back
// Executes queued items: frame stores, four box blur passes, blend, result.
// ----------------------------------------------------------------------------
`include "masked_box_blur_composite_defines.svh"

module mbbc_back #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_RADIUS = 31
) (
   input  logic                clock,
   input  logic                reset,
   input  mbbc_pkg::cfg_type   cfg,
   input  mbbc_pkg::qhead_type head,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_blue,
   output logic [7:0]          rsp_out_green,
   output logic [7:0]          rsp_out_red,
   output logic [7:0]          rsp_out_alpha,
   output logic                rsp_last_pixel,
   output logic                rsp_read_status
);
   import mbbc_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int DMW   = RW + 1;
   localparam int SUM_W = 8 + $clog2(2 * MAX_RADIUS + 2) + 1;
   localparam int DW    = CFG_DIM_W;
   localparam int XW    = DW + 1;
   localparam int PW    = 2 * DW;

   back_state_type state_ff, state_in;

   // Control registers
   logic [1:0]    pass_ff, pass_in;
   logic [DW-1:0] line_ff, line_in;
   logic [DW-1:0] x_ff, x_in;
   logic [RW:0]   j_ff, j_in;
   logic [CW-1:0] widx_ff, widx_in;
   logic [CW-1:0] ridx_ff, ridx_in;
   logic          ready_ff, ready_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [2:0][SUM_W-1:0] sum_ff, sum_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [DW-1:0]         fw_ff, fw_in, fh_ff, fh_in;
   logic [RW-1:0]         rad_ff, rad_in;
   logic [DMW-1:0]        diam_ff, diam_in;
   logic                  mode_ff, mode_in;
   logic [CW-1:0]         fpix_ff, fpix_in;
   logic [CW-1:0]         npix_ff;
   logic [2:0][15:0]      po_ff, pt_ff;
   logic [31:0]           orig_ff;
   logic [23:0]           other_ff;
   logic [7:0]            m_ff;
   logic [31:0]           out_px_ff, out_px_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_stat_ff, out_stat_in;

   // Clamped configuration
   logic [DW-1:0]  cw, ch;
   logic [RW-1:0]  cr;
   logic [PW-1:0]  area;

   // Pass geometry
   logic          horiz;
   logic [DW-1:0] len, lines, len_m1;
   logic [XW-1:0] j_x, r_x, x_x, pre_t, add_t, rem_t;
   logic [DW-1:0] pre_i, add_i, rem_i, idx_sel;
   logic [DW-1:0] mul_a, mul_b;
   logic [AW-1:0] addr_calc;

   // Memory ports
   logic          rd_en, src_we, a_we, b_we;
   logic [AW-1:0] raddr, kaddr;
   logic [31:0]   src_rd;
   logic [7:0]    mask_rd;
   logic [23:0]   bkd_rd, a_rd, b_rd, pass_rd;
   logic [CW-1:0] kidx, knext;

   // Divider
   logic            div_start, div_done;
   logic [2:0][7:0] div_q;

   // Blend
   logic [2:0][16:0] bsum;
   logic [2:0][16:0] bdiv;
   logic [31:0]      blend_px;
   logic             out_free, last_rd, pass_busy;

   // Clamp the registers to their legal ranges
   always_comb begin
      if (cfg.frame_width == '0) begin
         cw = DW'(1);
      end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
         cw = DW'(MAX_WIDTH);
      end else begin
         cw = cfg.frame_width;
      end
      if (cfg.frame_height == '0) begin
         ch = DW'(1);
      end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
         ch = DW'(MAX_HEIGHT);
      end else begin
         ch = cfg.frame_height;
      end
      if (32'(cfg.blur_radius) < MIN_RADIUS) begin
         cr = RW'(MIN_RADIUS);
      end else if (32'(cfg.blur_radius) > MAX_RADIUS) begin
         cr = RW'(MAX_RADIUS);
      end else begin
         cr = RW'(cfg.blur_radius);
      end
      area = PW'(cw) * PW'(ch);
   end

   // Pixel count of the configured frame, registered from the clamped configuration
   always_ff @(posedge clock) begin
      npix_ff <= CW'(area);
   end

   // Window indices for the current pass, clamped at the line edges
   always_comb begin
      horiz  = !pass_ff[0];
      len    = horiz ? fw_ff : fh_ff;
      lines  = horiz ? fh_ff : fw_ff;
      len_m1 = len - 1'b1;
      j_x    = XW'(j_ff);
      r_x    = XW'(rad_ff);
      x_x    = XW'(x_ff);
      pre_t  = j_x - r_x;
      add_t  = x_x + r_x + XW'(1);
      rem_t  = x_x - r_x;
      if (j_x < r_x) begin
         pre_i = '0;
      end else if (pre_t > XW'(len_m1)) begin
         pre_i = len_m1;
      end else begin
         pre_i = pre_t[DW-1:0];
      end
      add_i = (add_t > XW'(len_m1)) ? len_m1 : add_t[DW-1:0];
      rem_i = (x_x > r_x) ? rem_t[DW-1:0] : '0;
      unique case (state_ff)
         ST_DIV_S: idx_sel = x_ff;
         ST_WR:    idx_sel = add_i;
         ST_ADD_U: idx_sel = rem_i;
         default:  idx_sel = pre_i;
      endcase
      mul_a     = horiz ? line_ff : idx_sel;
      mul_b     = horiz ? idx_sel : line_ff;
      addr_calc = AW'(PW'(mul_a) * PW'(fw_ff) + PW'(mul_b));
   end

   // Memory control
   assign kidx    = ready_ff ? '0 : widx_ff;
   assign knext   = kidx + 1'b1;
   assign kaddr   = kidx[AW-1:0];
   assign rd_en   = (state_ff == ST_PRE_R) || (state_ff == ST_ADD_R) ||
                    (state_ff == ST_SUB_R) || (state_ff == ST_RD_F);
   assign raddr   = (state_ff == ST_RD_F) ? ridx_ff[AW-1:0] : addr_ff;
   assign src_we  = (state_ff == ST_IDLE) && cmd_pop && !head.cmd.is_read;
   assign a_we    = (state_ff == ST_WR) && !pass_ff[0];
   assign b_we    = (state_ff == ST_WR) && pass_ff[0];
   assign pass_rd = (pass_ff == 2'd0) ? src_rd[23:0] : ((pass_ff == 2'd2) ? b_rd : a_rd);

   mbbc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_src_ram (
      .clock (clock),
      .we    (src_we),
      .waddr (kaddr),
      .wdata ({head.cmd.pixel_alpha, head.cmd.pixel_red, head.cmd.pixel_green,
               head.cmd.pixel_blue}),
      .re    (rd_en),
      .raddr (raddr),
      .rdata (src_rd)
   );

   mbbc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_mask_ram (
      .clock (clock),
      .we    (src_we),
      .waddr (kaddr),
      .wdata (head.cmd.mask_level),
      .re    (rd_en),
      .raddr (raddr),
      .rdata (mask_rd)
   );

   mbbc_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_bkd_ram (
      .clock (clock),
      .we    (src_we),
      .waddr (kaddr),
      .wdata ({head.cmd.backdrop_red, head.cmd.backdrop_green, head.cmd.backdrop_blue}),
      .re    (rd_en),
      .raddr (raddr),
      .rdata (bkd_rd)
   );

   mbbc_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_work_a_ram (
      .clock (clock),
      .we    (a_we),
      .waddr (addr_ff),
      .wdata (div_q),
      .re    (rd_en),
      .raddr (raddr),
      .rdata (a_rd)
   );

   mbbc_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_work_b_ram (
      .clock (clock),
      .we    (b_we),
      .waddr (addr_ff),
      .wdata (div_q),
      .re    (rd_en),
      .raddr (raddr),
      .rdata (b_rd)
   );

   assign div_start = (state_ff == ST_DIV_S);

   mbbc_div #(.SUM_W(SUM_W), .DMW(DMW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (diam_ff),
      .quotient (div_q),
      .done     (div_done)
   );

   // Blend: round and divide by 255 with a shift-add
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         bsum[c] = 17'(po_ff[c]) + 17'(pt_ff[c]) + BLEND_ROUND;
         bdiv[c] = (bsum[c] + (bsum[c] >> 8) + 17'd1) >> 8;
      end
      if (m_ff == PIXEL_MAX) begin
         blend_px = orig_ff;
      end else if (m_ff == '0) begin
         blend_px = {PIXEL_MAX, other_ff};
      end else begin
         blend_px = {orig_ff[31:24], bdiv[2][7:0], bdiv[1][7:0], bdiv[0][7:0]};
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_rd   = (ridx_ff + 1'b1 == fpix_ff);
   assign pass_busy = (state_ff != ST_IDLE) && (state_ff != ST_RD_F) &&
                      (state_ff != ST_RD_M) && (state_ff != ST_RD_S);

   // Next state and register updates
   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      line_in      = line_ff;
      x_in         = x_ff;
      j_in         = j_ff;
      widx_in      = widx_ff;
      ridx_in      = ridx_ff;
      ready_in     = ready_ff;
      sum_in       = sum_ff;
      addr_in      = addr_ff;
      fw_in        = fw_ff;
      fh_in        = fh_ff;
      rad_in       = rad_ff;
      diam_in      = diam_ff;
      mode_in      = mode_ff;
      fpix_in      = fpix_ff;
      out_px_in    = out_px_ff;
      out_last_in  = out_last_ff;
      out_stat_in  = out_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd_pop      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid && (!head.cmd.is_read || out_free)) begin
               cmd_pop = 1'b1;
               if (!head.cmd.is_read) begin
                  // Store the pixel; a write drops a finished frame
                  ready_in = 1'b0;
                  if (knext >= npix_ff) begin
                     widx_in = '0;
                     fw_in   = cw;
                     fh_in   = ch;
                     rad_in  = cr;
                     diam_in = {cr, 1'b1};
                     mode_in = cfg.backdrop_mode;
                     fpix_in = npix_ff;
                     if (cfg.backdrop_mode) begin
                        ready_in = 1'b1;
                        ridx_in  = '0;
                     end else begin
                        pass_in  = '0;
                        line_in  = '0;
                        x_in     = '0;
                        j_in     = '0;
                        sum_in   = '0;
                        state_in = ST_PRE_A;
                     end
                  end else begin
                     widx_in = knext;
                  end
               end else if (!ready_ff) begin
                  // Nothing to read: answer with status set
                  out_px_in    = '0;
                  out_last_in  = 1'b0;
                  out_stat_in  = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = ST_RD_F;
               end
            end
         end
         ST_PRE_A: begin
            addr_in  = addr_calc;
            state_in = ST_PRE_R;
         end
         ST_PRE_R: begin
            state_in = ST_PRE_U;
         end
         ST_PRE_U: begin
            for (int c = 0; c < 3; c++) begin
               sum_in[c] = sum_ff[c] + SUM_W'(pass_rd[8*c +: 8]);
            end
            if (j_ff == {rad_ff, 1'b0}) begin
               j_in     = '0;
               state_in = ST_DIV_S;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_PRE_A;
            end
         end
         ST_DIV_S: begin
            addr_in  = addr_calc;
            state_in = ST_DIV_W;
         end
         ST_DIV_W: begin
            if (div_done) begin
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            addr_in  = addr_calc;
            state_in = ST_ADD_R;
         end
         ST_ADD_R: begin
            state_in = ST_ADD_U;
         end
         ST_ADD_U: begin
            for (int c = 0; c < 3; c++) begin
               sum_in[c] = sum_ff[c] + SUM_W'(pass_rd[8*c +: 8]);
            end
            addr_in  = addr_calc;
            state_in = ST_SUB_R;
         end
         ST_SUB_R: begin
            state_in = ST_SUB_U;
         end
         ST_SUB_U: begin
            for (int c = 0; c < 3; c++) begin
               sum_in[c] = sum_ff[c] - SUM_W'(pass_rd[8*c +: 8]);
            end
            if (x_ff == len_m1) begin
               // Line finished: advance line, then pass
               x_in   = '0;
               sum_in = '0;
               if (line_ff == lines - 1'b1) begin
                  line_in = '0;
                  if (pass_ff == 2'd3) begin
                     ready_in = 1'b1;
                     ridx_in  = '0;
                     state_in = ST_IDLE;
                  end else begin
                     pass_in  = pass_ff + 1'b1;
                     state_in = ST_PRE_A;
                  end
               end else begin
                  line_in  = line_ff + 1'b1;
                  state_in = ST_PRE_A;
               end
            end else begin
               x_in     = x_ff + 1'b1;
               state_in = ST_DIV_S;
            end
         end
         ST_RD_F: begin
            state_in = ST_RD_M;
         end
         ST_RD_M: begin
            state_in = ST_RD_S;
         end
         ST_RD_S: begin
            if (out_free) begin
               out_px_in    = blend_px;
               out_last_in  = last_rd;
               out_stat_in  = 1'b0;
               rsp_valid_in = 1'b1;
               ridx_in      = ridx_ff + 1'b1;
               if (last_rd) begin
                  ready_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff      <= '0;
         line_ff      <= '0;
         x_ff         <= '0;
         j_ff         <= '0;
         widx_ff      <= '0;
         ridx_ff      <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pass_ff      <= pass_in;
         line_ff      <= line_in;
         x_ff         <= x_in;
         j_ff         <= j_in;
         widx_ff      <= widx_in;
         ridx_ff      <= ridx_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers; the read path latches memory data and products
   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      addr_ff     <= addr_in;
      fw_ff       <= fw_in;
      fh_ff       <= fh_in;
      rad_ff      <= rad_in;
      diam_ff     <= diam_in;
      mode_ff     <= mode_in;
      fpix_ff     <= fpix_in;
      out_px_ff   <= out_px_in;
      out_last_ff <= out_last_in;
      out_stat_ff <= out_stat_in;
      if (state_ff == ST_RD_M) begin
         orig_ff  <= src_rd;
         other_ff <= mode_ff ? bkd_rd : b_rd;
         m_ff     <= mask_rd;
         for (int c = 0; c < 3; c++) begin
            po_ff[c] <= 16'(src_rd[8*c +: 8]) * 16'(mask_rd);
            pt_ff[c] <= 16'(mode_ff ? bkd_rd[8*c +: 8] : b_rd[8*c +: 8]) *
                        16'(PIXEL_MAX - mask_rd);
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_blue    = out_px_ff[7:0];
   assign rsp_out_green   = out_px_ff[15:8];
   assign rsp_out_red     = out_px_ff[23:16];
   assign rsp_out_alpha   = out_px_ff[31:24];
   assign rsp_last_pixel  = out_last_ff;
   assign rsp_read_status = out_stat_ff;

   `MBBC_ASSERT_IMP(a_pass_no_frame, clock, reset, pass_busy, !ready_ff, "frame ready during blur")
   `MBBC_ASSERT_IMP(a_fetch_ready, clock, reset, state_ff == ST_RD_F, ready_ff, "fetch without frame")
   `MBBC_ASSERT_IMP(a_pop_idle, clock, reset, cmd_pop, state_ff == ST_IDLE, "pop outside idle")
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the masked box blur compositor. A directed table
// covers reset, one-pixel frames, both modes, mask extremes, dropped frames,
// empty reads and out-of-range registers; random frames of varied size,
// radius and mode follow. Results are checked against an in-bench model.
// ----------------------------------------------------------------------------
module testbench;
   import mbbc_pkg::*;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
      logic       last;
      logic       status;
   } pix_result_type;

   typedef struct {
      bit             is_cfg;
      csr_index_type  idx;
      logic [10:0]    val;
      cmd_type        cmd;
      bit             typed;
      pix_result_type res;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = 1'b0;
   logic [7:0] req_pixel_blue = '0, req_pixel_green = '0, req_pixel_red = '0;
   logic [7:0] req_pixel_alpha = '0, req_mask_level = '0;
   logic [7:0] req_backdrop_blue = '0, req_backdrop_green = '0, req_backdrop_red = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_out_blue, rsp_out_green, rsp_out_red, rsp_out_alpha;
   logic rsp_last_pixel, rsp_read_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   masked_box_blur_composite u_top (.*);

   // Compositor model state
   logic [10:0] mdl_width, mdl_height;
   logic [4:0]  mdl_radius;
   logic        mdl_mode;
   int          wr_idx, rd_idx, frame_n;
   bit          frame_done;
   logic [31:0] src_mem [int];
   logic [7:0]  mask_mem [int];
   logic [23:0] bkd_mem [int];
   logic [23:0] back_frame [];

   pix_result_type expected_pixels [$];
   int send_pct, recv_pct;
   int n_items, n_fail;
   dir_row_type rows [$];

   initial forever #4 clock = ~clock;

   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int clamp_dim(logic [10:0] v);
      if (v == 0) return 1;
      if (v > 1024) return 1024;
      return v;
   endfunction

   // One box pass with clamped edges over lines of len elements
   function automatic void box_pass(input logic [23:0] src [], output logic [23:0] dst [],
                                    input int lines, input int len, input int line_step,
                                    input int elem_step, input int r);
      int diam, base, idx, add, rem;
      int sum [3];
      diam = 2 * r + 1;
      dst = new[src.size()];
      for (int l = 0; l < lines; l++) begin
         base = l * line_step;
         sum = '{0, 0, 0};
         for (int i = -r; i <= r; i++) begin
            idx = (i < 0) ? 0 : i;
            if (idx > len - 1) idx = len - 1;
            for (int c = 0; c < 3; c++) sum[c] += src[base + idx * elem_step][8*c +: 8];
         end
         for (int x = 0; x < len; x++) begin
            rem = (x > r) ? x - r : 0;
            add = x + r + 1;
            if (add > len - 1) add = len - 1;
            for (int c = 0; c < 3; c++) begin
               dst[base + x * elem_step][8*c +: 8] = 8'((sum[c] / diam) & 8'hFF);
               sum[c] += src[base + add * elem_step][8*c +: 8];
               sum[c] -= src[base + rem * elem_step][8*c +: 8];
            end
         end
      end
   endfunction

   // Build the background frame at completion
   function automatic void finish_frame(int w, int h);
      logic [23:0] a [];
      logic [23:0] b [];
      int r;
      frame_n = w * h;
      back_frame = new[frame_n];
      if (mdl_mode) begin
         for (int k = 0; k < frame_n; k++) back_frame[k] = bkd_mem[k];
      end else begin
         r = mdl_radius;
         if (r > 31) r = 31;
         if (r < MIN_RADIUS) r = MIN_RADIUS;
         a = new[frame_n];
         for (int k = 0; k < frame_n; k++) a[k] = src_mem[k][23:0];
         box_pass(a, b, h, w, w, 1, r);
         box_pass(b, a, w, h, 1, w, r);
         box_pass(a, b, h, w, w, 1, r);
         box_pass(b, a, w, h, 1, w, r);
         back_frame = a;
      end
      frame_done = 1;
      rd_idx = 0;
   endfunction

   // Advance the model by one item; return 1 when it yields a result
   function automatic bit predict_step(cmd_type c, output pix_result_type res);
      int w, h, m, v;
      logic [31:0] orig, other, px;
      w = clamp_dim(mdl_width);
      h = clamp_dim(mdl_height);
      res = '0;
      if (c.is_read == REQ_WRITE) begin
         if (frame_done) begin
            frame_done = 0;
            wr_idx = 0;
         end
         src_mem[wr_idx] = {c.pixel_alpha, c.pixel_red, c.pixel_green, c.pixel_blue};
         mask_mem[wr_idx] = c.mask_level;
         bkd_mem[wr_idx] = {c.backdrop_red, c.backdrop_green, c.backdrop_blue};
         wr_idx++;
         if (wr_idx >= w * h) begin
            wr_idx = 0;
            finish_frame(w, h);
         end
         return 0;
      end
      if (!frame_done || rd_idx >= frame_n) begin
         res.status = 1'b1;
         return 1;
      end
      orig = src_mem[rd_idx];
      other = {PIXEL_MAX, back_frame[rd_idx]};
      m = mask_mem[rd_idx];
      if (m == 255) px = orig;
      else if (m == 0) px = other;
      else begin
         px = {orig[31:24], 24'h0};
         for (int k = 0; k < 3; k++) begin
            v = (orig[8*k +: 8] * m + other[8*k +: 8] * (255 - m) + 127) / 255;
            px[8*k +: 8] = 8'(v);
         end
      end
      res = '{px[7:0], px[15:8], px[23:16], px[31:24], rd_idx + 1 == frame_n, 1'b0};
      rd_idx++;
      if (res.last) frame_done = 0;
      return 1;
   endfunction

   // Drive one item and hold it until accepted
   task automatic send_item(cmd_type c, bit typed, pix_result_type tres);
      pix_result_type pres;
      while ($urandom_range(0, 99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= c.is_read;
      req_pixel_blue <= c.pixel_blue;
      req_pixel_green <= c.pixel_green;
      req_pixel_red <= c.pixel_red;
      req_pixel_alpha <= c.pixel_alpha;
      req_mask_level <= c.mask_level;
      req_backdrop_blue <= c.backdrop_blue;
      req_backdrop_green <= c.backdrop_green;
      req_backdrop_red <= c.backdrop_red;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (predict_step(c, pres)) expected_pixels.push_back(typed ? tres : pres);
      n_items++;
   endtask

   // Drop valid and wait until every result has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type i, logic [10:0] v);
      csr_valid <= 1'b1;
      csr_index <= i;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (i)
         CSR_FRAME_WIDTH:   mdl_width = v;
         CSR_FRAME_HEIGHT:  mdl_height = v;
         CSR_BLUR_RADIUS:   mdl_radius = v[4:0];
         CSR_BACKDROP_MODE: mdl_mode = v[0];
      endcase
   endtask

   task automatic configure(logic [10:0] w, logic [10:0] h, logic [10:0] r, logic [10:0] m);
      wait_idle();
      csr_write(CSR_FRAME_WIDTH, w);
      csr_write(CSR_FRAME_HEIGHT, h);
      csr_write(CSR_BLUR_RADIUS, r);
      csr_write(CSR_BACKDROP_MODE, m);
      csr_valid <= 1'b0;
   endtask

   function automatic cmd_type rand_pixel();
      cmd_type c;
      c = cmd_type'({$urandom, $urandom, $urandom});
      c.is_read = REQ_WRITE;
      case ($urandom_range(0, 3))
         0: c.mask_level = 8'd0;
         1: c.mask_level = PIXEL_MAX;
         default: ;
      endcase
      return c;
   endfunction

   function automatic cmd_type read_cmd();
      cmd_type c;
      c = cmd_type'({$urandom, $urandom, $urandom});
      c.is_read = REQ_READ;
      return c;
   endfunction

   // Load one frame, then read it back with occasional noise
   task automatic run_frame(logic [10:0] w, logic [10:0] h, int reads);
      int n;
      configure(w, h, $urandom_range(0, 3) == 0 ? 31 : $urandom_range(0, 31),
                $urandom_range(0, 1));
      n = clamp_dim(w) * clamp_dim(h);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 12) send_item(read_cmd(), 0, '0);
         send_item(rand_pixel(), 0, '0);
      end
      if (reads < 0) reads = n + $urandom_range(0, 2);
      for (int k = 0; k < reads; k++) begin
         case ($urandom_range(0, 99))
            0, 1:    send_item(rand_pixel(), 0, '0);
            2, 3, 4: configure($urandom_range(0, 6), $urandom_range(0, 6),
                               $urandom_range(0, 31), $urandom_range(0, 1));
            default: ;
         endcase
         send_item(read_cmd(), 0, '0);
      end
   endtask

   function automatic void add_cfg(csr_index_type i, logic [10:0] v);
      dir_row_type d;
      d = '{1, i, v, '0, 0, '0};
      rows.push_back(d);
   endfunction

   function automatic void add_wr(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic [7:0] a,
                                  logic [7:0] m, logic [7:0] bb, logic [7:0] bg,
                                  logic [7:0] br);
      dir_row_type d;
      d = '{0, CSR_FRAME_WIDTH, 0, {REQ_WRITE, b, g, r, a, m, bb, bg, br}, 0, '0};
      rows.push_back(d);
   endfunction

   function automatic void add_rd(bit typed, pix_result_type res);
      dir_row_type d;
      d = '{0, CSR_FRAME_WIDTH, 0, {REQ_READ, 64'h0}, typed, res};
      rows.push_back(d);
   endfunction

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      pix_result_type got, want;
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= $urandom_range(0, 99) >= recv_pct;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_out_blue, rsp_out_green, rsp_out_red, rsp_out_alpha,
                 rsp_last_pixel, rsp_read_status};
         if (expected_pixels.size() == 0) begin
            n_fail++;
            if (n_fail <= 10) $display("unexpected result item %p", got);
         end else begin
            want = expected_pixels.pop_front();
            if (got !== want) begin
               n_fail++;
               if (n_fail <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   initial begin
      mdl_width = WIDTH_RST;
      mdl_height = HEIGHT_RST;
      mdl_radius = RADIUS_RST;
      mdl_mode = 0;
      wr_idx = 0;
      rd_idx = 0;
      frame_n = 0;
      frame_done = 0;
      n_items = 0;
      n_fail = 0;
      send_pct = 36;
      recv_pct = 53;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: one-pixel frames, both modes, drops, clamped sizes
      add_rd(1, '{0, 0, 0, 0, 0, 1});
      add_cfg(CSR_FRAME_WIDTH, 1);
      add_cfg(CSR_FRAME_HEIGHT, 1);
      add_cfg(CSR_BLUR_RADIUS, 0);
      add_cfg(CSR_BACKDROP_MODE, 0);
      add_wr(8'h11, 8'h22, 8'h33, 8'h44, 8'hFF, 8'h01, 8'h02, 8'h03);
      add_rd(1, '{8'h11, 8'h22, 8'h33, 8'h44, 1, 0});
      add_rd(1, '{0, 0, 0, 0, 0, 1});
      add_wr(8'h10, 8'h20, 8'h30, 8'h40, 8'h00, 8'hAA, 8'hBB, 8'hCC);
      add_rd(1, '{8'h10, 8'h20, 8'h30, 8'hFF, 1, 0});
      add_wr(8'hFF, 8'h00, 8'h80, 8'h00, 8'h80, 8'h00, 8'hFF, 8'h7F);
      add_rd(0, '0);
      add_cfg(CSR_BACKDROP_MODE, 1);
      add_wr(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h05, 8'h06, 8'h07);
      add_rd(1, '{8'h05, 8'h06, 8'h07, 8'hFF, 1, 0});
      add_wr(8'h00, 8'hFF, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'hFF);
      add_rd(0, '0);
      add_cfg(CSR_FRAME_WIDTH, 2);
      add_wr(8'h01, 8'h02, 8'h03, 8'h04, 8'hFE, 8'h10, 8'h20, 8'h30);
      add_wr(8'h05, 8'h06, 8'h07, 8'h08, 8'h40, 8'h50, 8'h60, 8'h70);
      add_wr(8'h09, 8'h0A, 8'h0B, 8'h0C, 8'hC0, 8'h90, 8'hA0, 8'hB0);
      add_rd(1, '{0, 0, 0, 0, 0, 1});
      add_wr(8'hF0, 8'hE0, 8'hD0, 8'hC0, 8'h00, 8'h0F, 8'h0E, 8'h0D);
      add_rd(0, '0);
      add_rd(0, '0);
      add_rd(1, '{0, 0, 0, 0, 0, 1});
      add_cfg(CSR_FRAME_WIDTH, 0);
      add_cfg(CSR_FRAME_HEIGHT, 0);
      add_cfg(CSR_BLUR_RADIUS, 31);
      add_cfg(CSR_BACKDROP_MODE, 0);
      add_wr(8'h7F, 8'h80, 8'hFF, 8'h00, 8'h7F, 8'h00, 8'h00, 8'h00);
      add_rd(0, '0);
      foreach (rows[i]) begin
         if (rows[i].is_cfg) begin
            wait_idle();
            csr_write(rows[i].idx, rows[i].val);
            csr_valid <= 1'b0;
         end else begin
            send_item(rows[i].cmd, rows[i].typed, rows[i].res);
         end
      end

      // Random frames under three idling patterns
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin send_pct = 36; recv_pct = 53; end
            1: begin send_pct = 53; recv_pct = 36; end
            default: begin send_pct = 0; recv_pct = 0; end
         endcase
         // One widest frame, clamped from an oversized width
         if (p == 2) begin
            configure(2047, 1, 3, 0);
            for (int k = 0; k < 1024; k++) send_item(rand_pixel(), 0, '0);
            for (int k = 0; k < 3; k++) send_item(read_cmd(), 0, '0);
         end
         while (n_items < ((p == 2) ? 1900 : (p + 1) * 300)) begin
            if ($urandom_range(0, 5) == 0)
               run_frame($urandom_range(1, 16), 1, -1);
            else
               run_frame($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 6),
                         $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 6), -1);
         end
      end

      // Drain and report
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (n_fail == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
